### rtl/extended_cigar_builder_defines.svh
// assertion macros for the extended cigar builder
// expects signals named clock and reset in the module that uses them
`ifndef EXTENDED_CIGAR_BUILDER_DEFINES_SVH
`define EXTENDED_CIGAR_BUILDER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ECB_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define ECB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ecb_pkg.sv
// shared types, codes and helpers for the extended cigar builder
// no dependencies
package ecb_pkg;

   localparam int LenBits            = 28;
   localparam int LengthBitsDefault  = 28;
   localparam int OutDepth           = 4;
   localparam int OutPtrBits         = $clog2(OutDepth);
   localparam int OutCntBits         = $clog2(OutDepth + 1);

   localparam logic       OpEntry    = 1'b0;
   localparam logic       OpPair     = 1'b1;
   localparam logic [3:0] CodeMatch  = 4'd0;
   localparam logic [3:0] CodeEqual  = 4'd7;
   localparam logic [3:0] CodeDiff   = 4'd8;
   localparam logic [7:0] BaseN      = 8'd78;
   localparam logic [7:0] CaseGap    = 8'd32;

   typedef struct packed {
      logic               op;
      logic [3:0]         cigar_code;
      logic [LenBits-1:0] cigar_length;
      logic [7:0]         read_base;
      logic [7:0]         ref_base;
      logic               read_end;
   } req_type;

   typedef struct packed {
      logic [3:0]         out_code;
      logic [LenBits-1:0] out_length;
      logic [LenBits-1:0] mismatch_total;
      logic               last;
   } rsp_type;

   // up to two results formed from one beat
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      logic [OutCntBits-1:0] level;
      logic                  room_two;
   } queue_status_type;

   // read base counts as agreeing: exact, lowercase reference, or read N
   function automatic logic base_agrees(input logic [7:0] rd, input logic [7:0] rf);
      logic lower;
      lower = (rf >= CaseGap) && (rd == (rf - CaseGap));
      return (rd == rf) || lower || (rd == BaseN);
   endfunction

endpackage

### rtl/ecb_core.sv
// input register, run/count state and result formation
// depends on ecb_pkg
module ecb_core #(
   parameter int LENGTH_BITS = ecb_pkg::LengthBitsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ecb_pkg::req_type          req_data,
   input  ecb_pkg::queue_status_type queue_status,
   output ecb_pkg::push_type         push
);

   localparam int FieldBits = ecb_pkg::LenBits;
   localparam logic [LENGTH_BITS-1:0] LenOne = LENGTH_BITS'(1);

   logic             in_valid_ff, in_valid_in;
   ecb_pkg::req_type in_data_ff;
   logic             advance;
   logic             accept;

   logic [LENGTH_BITS-1:0] run_ff, run_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [LENGTH_BITS-1:0] cnt_ff, cnt_in;
   logic [LENGTH_BITS-1:0] cnt_new;
   logic [LENGTH_BITS-1:0] run_inc;
   logic [LENGTH_BITS-1:0] len_cut;
   logic [LENGTH_BITS-1:0] len0, len1;
   logic [3:0]             code0, code1;
   logic [1:0]             n;
   logic                   agree;

   assign advance   = in_valid_ff && queue_status.room_two;
   assign req_stall = in_valid_ff && !queue_status.room_two;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
   end

   assign len_cut = in_data_ff.cigar_length[LENGTH_BITS-1:0];
   assign agree   = ecb_pkg::base_agrees(in_data_ff.read_base, in_data_ff.ref_base);
   assign run_inc = (run_ff == '1) ? run_ff : run_ff + LenOne;

   always_comb begin
      run_in  = run_ff;
      rem_in  = rem_ff;
      cnt_new = cnt_ff;
      cnt_in  = cnt_ff;
      n       = 2'd0;
      code0   = ecb_pkg::CodeDiff;
      len0    = LenOne;
      code1   = ecb_pkg::CodeDiff;
      len1    = LenOne;
      if (advance) begin
         if (in_data_ff.op == ecb_pkg::OpEntry) begin
            // a new entry drops any unfinished run
            run_in = '0;
            if (in_data_ff.cigar_code == ecb_pkg::CodeMatch) begin
               rem_in = len_cut;
            end else begin
               rem_in = '0;
               n      = 2'd1;
               code0  = in_data_ff.cigar_code;
               len0   = len_cut;
            end
         end else if (rem_ff != '0) begin
            rem_in = rem_ff - LenOne;
            if (!agree) begin
               cnt_new = (cnt_ff == '1) ? cnt_ff : cnt_ff + LenOne;
               run_in  = '0;
               if (run_ff != '0) begin
                  n     = 2'd2;
                  code0 = ecb_pkg::CodeEqual;
                  len0  = run_ff;
               end else begin
                  n = 2'd1;
               end
            end else begin
               run_in = run_inc;
               // last pair of the match flushes the run
               if (rem_ff == LenOne) begin
                  n      = 2'd1;
                  code0  = ecb_pkg::CodeEqual;
                  len0   = run_inc;
                  run_in = '0;
               end
            end
         end
         cnt_in = in_data_ff.read_end ? '0 : cnt_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      push.count                 = n;
      push.first.out_code        = code0;
      push.first.out_length      = FieldBits'(len0);
      push.first.mismatch_total  = FieldBits'(cnt_new);
      push.first.last            = (n == 2'd1);
      push.second.out_code       = code1;
      push.second.out_length     = FieldBits'(len1);
      push.second.mismatch_total = FieldBits'(cnt_new);
      push.second.last           = 1'b1;
   end

endmodule

### rtl/ecb_out_queue.sv
// small result queue taking up to two results a cycle, one out per beat while rsp_stall is low
// depends on ecb_pkg
module ecb_out_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  ecb_pkg::push_type         push,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ecb_pkg::rsp_type          rsp_data,
   output ecb_pkg::queue_status_type queue_status
);

   localparam int PtrBits = ecb_pkg::OutPtrBits;
   localparam int CntBits = ecb_pkg::OutCntBits;
   localparam logic [CntBits-1:0] RoomLimit = CntBits'(ecb_pkg::OutDepth - 2);

   ecb_pkg::rsp_type entry_ff [ecb_pkg::OutDepth];

   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0] level_ff, level_in;
   logic [PtrBits-1:0] wr_next;
   logic               pop;

   assign rsp_valid = (level_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign wr_next   = wr_ptr_ff + PtrBits'(1);

   assign wr_ptr_in = wr_ptr_ff + PtrBits'(push.count);
   assign rd_ptr_in = pop ? rd_ptr_ff + PtrBits'(1) : rd_ptr_ff;
   assign level_in  = level_ff + CntBits'(push.count) - CntBits'(pop);

   assign queue_status.level    = level_ff;
   assign queue_status.room_two = (level_ff <= RoomLimit);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

### rtl/extended_cigar_builder.sv
// with an empty queue, a beat passes the input register and then the result queue before
// its first result is offered
// throughput: one input beat per cycle while the result queue has two free entries; a beat
// with two results is soaked up by a four-entry result queue; a held beat stalls the input
// until the queue has two free entries
// reset: synchronous, clears run, pending pair count, mismatch count and empties the queue
`include "extended_cigar_builder_defines.svh"

module extended_cigar_builder #(
   parameter int LENGTH_BITS = ecb_pkg::LengthBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ecb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ecb_pkg::rsp_type rsp_data
);

   ecb_pkg::push_type         push;
   ecb_pkg::queue_status_type queue_status;

   ecb_core #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .queue_status(queue_status),
      .push        (push)
   );

   ecb_out_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .queue_status(queue_status)
   );

   `ECB_ASSERT_IMP(a_queue_bound, 1'b1,
      queue_status.level <= ecb_pkg::OutDepth, "result queue overflow")
   `ECB_ASSERT_IMP(a_pair_form, push.count == 2'd2,
      (push.first.out_code == ecb_pkg::CodeEqual) &&
      (push.second.out_code == ecb_pkg::CodeDiff) &&
      (push.second.mismatch_total != '0), "bad two-result beat")
   `ECB_ASSERT_NEXT(a_push_shows, push.count != 2'd0, rsp_valid, "pushed result not offered")

endmodule
